[hw/rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, disabled in reset
`define PXG_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication into the next cycle, disabled in reset
`define PXG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// implication into the next cycle, checked during reset too
`define PXG_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/pxg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package pxg_pkg;

  localparam int TEXTURE_WIDTH_DEF  = 320;
  localparam int TEXTURE_HEIGHT_DEF = 240;

  localparam int CORDIC_STEPS = 16;
  localparam int HALF_TURN    = 65536;
  localparam int INV_GAIN_Q16 = 39797;

  localparam int DW = 12;
  localparam int XW = 30;
  localparam int ZW = 19;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 10;

  localparam logic [CFG_IW-1:0] REG_ROTATION = 3'd0;
  localparam logic [CFG_IW-1:0] REG_ZOOM     = 3'd1;
  localparam logic [CFG_IW-1:0] REG_COLOR    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_SYMMETRY = 3'd3;
  localparam logic [CFG_IW-1:0] REG_SCALE    = 3'd4;

  localparam int ATAN_TAB [CORDIC_STEPS] = '{
    16384, 9672, 5110, 2594, 1302, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1
  };

  typedef struct packed {
    logic                 valid;
    logic                 center;
    logic [7:0]           frame;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  typedef logic [15:0] palette_t [256];

  function automatic longint fx_sin(longint phase);
    longint a;
    longint x;
    longint y;
    longint xs;
    longint ys;
    a = phase % (2 * HALF_TURN);
    x = INV_GAIN_Q16;
    y = 0;
    if (a >= HALF_TURN) a = a - 2 * HALF_TURN;
    if (a > HALF_TURN / 2) a = HALF_TURN - a;
    else if (a < -(HALF_TURN / 2)) a = -HALF_TURN - a;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (a >= 0) begin
        x = x - ys;
        y = y + xs;
        a = a - ATAN_TAB[i];
      end else begin
        x = x + ys;
        y = y - xs;
        a = a + ATAN_TAB[i];
      end
    end
    return y;
  endfunction

  function automatic longint chan(longint phase);
    longint t;
    t = 127 * longint'(HALF_TURN) + 127 * fx_sin(phase);
    if (t < 0) t = 0;
    t = t >>> 16;
    if (t > 255) t = 255;
    return t;
  endfunction

  function automatic palette_t palette_build();
    palette_t p;
    longint   base;
    longint   r;
    longint   g;
    longint   b;
    for (int i = 0; i < 256; i++) begin
      base = longint'(i) * 534035;
      r = chan((base + 128) >>> 8);
      g = chan((base + 10680707 + 128) >>> 8);
      b = chan((base + 21361415 + 128) >>> 8);
      if ((i % 32) < 4) begin
        r = 255;
        g = 255;
        b = 255;
      end
      p[i] = {r[7:3], g[7:2], b[7:3]};
    end
    return p;
  endfunction

  localparam palette_t PALETTE = palette_build();

endpackage
`default_nettype wire

[hw/rtl/pxg_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface pxg_in_if;
  logic       valid;
  logic       ready;
  logic [8:0] pixel_x;
  logic [7:0] pixel_y;
  logic [7:0] frame_index;

  modport source (output valid, pixel_x, pixel_y, frame_index, input ready);
  modport sink   (input valid, pixel_x, pixel_y, frame_index, output ready);
endinterface
`default_nettype wire

[hw/rtl/pxg_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface pxg_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_rgb565;

  modport source (output valid, pixel_rgb565, input ready);
  modport sink   (input valid, pixel_rgb565, output ready);
endinterface
`default_nettype wire

[hw/rtl/pxg_cordic_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module pxg_cordic_cell import pxg_pkg::*; #(
  parameter int STEP = 0
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    adv,
  input  wire cordic_t d,
  output cordic_t      q
);

  cordic_t              q_next;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;

  always_comb begin
    xs     = d.x >>> STEP;
    ys     = d.y >>> STEP;
    q_next = d;
    if (!d.y[XW-1]) begin
      q_next.x = d.x + ys;
      q_next.y = d.y - xs;
      q_next.z = d.z + ZW'(ATAN_TAB[STEP]);
    end else begin
      q_next.x = d.x - ys;
      q_next.y = d.y + xs;
      q_next.z = d.z - ZW'(ATAN_TAB[STEP]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (adv) begin
      q <= q_next;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/polar_xor_pixel_generator.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel   | dir | payload
// pix_in    | in  | pixel_x[8:0], pixel_y[7:0], frame_index[7:0]
// pix_out   | out | pixel_rgb565[15:0]
// cfg_*     | in  | cfg_index[2:0], cfg_data[9:0]
// One pixel per cycle unless the output stalls; stages: entry stage, 16 CORDIC cells,
// two multiply stages, then the palette lookup into the output register.
// Synchronous reset clears every valid bit; registers reset to their listed values.
// A stalled output holds the whole chain, and pix_in.ready follows it.
module polar_xor_pixel_generator import pxg_pkg::*; #(
  parameter int TEXTURE_WIDTH  = TEXTURE_WIDTH_DEF,
  parameter int TEXTURE_HEIGHT = TEXTURE_HEIGHT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  pxg_in_if.sink                 pix_in,
  pxg_out_if.source              pix_out,
  input  wire logic              cfg_write,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data
);

  localparam logic signed [DW-1:0] HALF_W = DW'(TEXTURE_WIDTH / 2);
  localparam logic signed [DW-1:0] HALF_H = DW'(TEXTURE_HEIGHT / 2);

  logic [7:0] rotation_speed;
  logic [7:0] zoom_speed;
  logic [7:0] color_speed;
  logic [3:0] symmetry_count;
  logic [9:0] radius_scale_q8;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_speed  <= 8'd1;
      zoom_speed      <= 8'd2;
      color_speed     <= 8'd3;
      symmetry_count  <= 4'd3;
      radius_scale_q8 <= 10'd384;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROTATION: rotation_speed  <= cfg_data[7:0];
        REG_ZOOM:     zoom_speed      <= cfg_data[7:0];
        REG_COLOR:    color_speed     <= cfg_data[7:0];
        REG_SYMMETRY: symmetry_count  <= cfg_data[3:0];
        REG_SCALE:    radius_scale_q8 <= cfg_data;
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv          = !pix_out.valid || pix_out.ready;
  assign pix_in.ready = adv;

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  cordic_t              entry_next;
  cordic_t              entry;

  always_comb begin
    dx = $signed({3'b000, pix_in.pixel_x}) - HALF_W;
    dy = $signed({4'b0000, pix_in.pixel_y}) - HALF_H;
    entry_next.valid  = pix_in.valid;
    entry_next.center = (dx == '0) && (dy == '0);
    entry_next.frame  = pix_in.frame_index;
    entry_next.x      = XW'($signed({dx, 16'h0000}));
    entry_next.y      = XW'($signed({dy, 16'h0000}));
    entry_next.z      = '0;
    if (dx[DW-1]) begin
      entry_next.x = -entry_next.x;
      entry_next.y = -entry_next.y;
      entry_next.z = dy[DW-1] ? -ZW'(HALF_TURN) : ZW'(HALF_TURN);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (adv) begin
      entry <= entry_next;
    end
  end

  cordic_t chain [CORDIC_STEPS+1];
  assign chain[0] = entry;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    pxg_cordic_cell #(.STEP(i)) u_cell (
      .clk (clk),
      .rst (rst),
      .adv (adv),
      .d   (chain[i]),
      .q   (chain[i+1])
    );
  end

  cordic_t last;
  assign last = chain[CORDIC_STEPS];

  logic signed [ZW-1:0] zs;
  logic signed [ZW+4:0] t;
  logic [7:0]           ucode_next;

  always_comb begin
    zs = last.center ? ZW'(HALF_TURN) : last.z + ZW'(HALF_TURN);
    t  = zs * $signed({1'b0, symmetry_count});
    ucode_next = t[ZW+4] ? 8'd0 : t[16:9];
  end

  logic        m1_valid;
  logic [7:0]  m1_frame;
  logic [7:0]  m1_ucode;
  logic [44:0] m1_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else if (adv) begin
      m1_valid <= last.valid;
      m1_frame <= last.frame;
      m1_ucode <= ucode_next;
      m1_prod  <= (last.center ? 29'd0 : last.x[28:0]) * 16'(INV_GAIN_Q16);
    end
  end

  logic        m2_valid;
  logic [7:0]  m2_frame;
  logic [7:0]  m2_ucode;
  logic [38:0] m2_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else if (adv) begin
      m2_valid <= m1_valid;
      m2_frame <= m1_frame;
      m2_ucode <= m1_ucode;
      m2_prod  <= m1_prod[44:16] * radius_scale_q8;
    end
  end

  logic [7:0] u;
  logic [7:0] v;
  logic [7:0] idx;

  always_comb begin
    u   = m2_ucode + 8'(rotation_speed * m2_frame);
    v   = m2_prod[31:24] - 8'(zoom_speed * m2_frame);
    idx = (u ^ v) + 8'(color_speed * m2_frame);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else if (adv) begin
      pix_out.valid        <= m2_valid;
      pix_out.pixel_rgb565 <= PALETTE[idx];
    end
  end

  `include "assert_macros.svh"

  `PXG_ASSERT_SAME(a_stall_holds_input, clk, rst, pix_out.valid && !pix_out.ready, !pix_in.ready)
  `PXG_ASSERT_NEXT(a_last_to_out, clk, rst, adv && m2_valid, pix_out.valid)
  `PXG_ASSERT_NEXT(a_entry_to_chain, clk, rst, adv && entry.valid, chain[1].valid)
  `PXG_ASSERT_ALWAYS(a_reset_empties, clk, rst, !pix_out.valid && !entry.valid)

endmodule
`default_nettype wire
